>>> hw/rtl/lbs_pkg.sv
`timescale 1ns / 1ps
package lbs_pkg;
	localparam int BONE_COUNT = 100;
	localparam int INFLUENCE_COUNT = 4;
	localparam int ENTRY_COUNT = 12;
	localparam int BONE_AW = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
	localparam int INF_W = (INFLUENCE_COUNT > 1) ? $clog2(INFLUENCE_COUNT) : 1;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_SKIN = 1'b1
	} op_t;

	typedef logic [ENTRY_COUNT-1:0][31:0] bone_mat_t;

	typedef struct packed {
		logic               en;
		logic [BONE_AW-1:0] bone;
		logic [3:0]         entry;
		logic [31:0]        value;
	} mem_wr_t;
endpackage

>>> hw/rtl/lbs_bone_mem.sv
`timescale 1ns / 1ps
module lbs_bone_mem
	import lbs_pkg::*;
(
	input  logic               clk,
	input  mem_wr_t            wr,
	input  logic               rd_en,
	input  logic [BONE_AW-1:0] rd_addr,
	output bone_mat_t          rd_data
);
	for (genvar e = 0; e < ENTRY_COUNT; e++) begin : g_lane
		logic [31:0] mem [BONE_COUNT];
		logic [31:0] rd_q;
		always_ff @(posedge clk) begin
			if (wr.en && wr.entry == 4'(e)) begin
				mem[wr.bone] <= wr.value;
			end
			if (rd_en) begin
				rd_q <= mem[rd_addr];
			end
		end
		assign rd_data[e] = rd_q;
	end
endmodule

>>> hw/rtl/linear_blend_vertex_skinning.sv
`timescale 1ns / 1ps
// channel   dir  tdata                                                  tuser
// s_axis    in   load_bone, load_entry, load_value, pos_x, pos_y,        opcode
//                pos_z, influence_weights, influence_bones
// m_axis    out  skinned_x, skinned_y, skinned_z                         status
//
// a vertex beat is held until its INFLUENCE_COUNT (4) influences are issued,
// one influence per cycle while m_axis does not stall, set by the single wide
// bone matrix read port; m_tvalid is registered after the last stage
// reset clears all valid bits; the bone store holds garbage until loaded
// a stall on m_axis freezes every stage and drops s_tready
module linear_blend_vertex_skinning
	import lbs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// load_bone, load_entry, load_value, pos_x, pos_y, pos_z, influence_weights,
	// influence_bones, zero pad
	input  logic [239:0] s_tdata,
	// opcode
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// skinned_x, skinned_y, skinned_z
	output logic [95:0]  m_tdata,
	// status
	output logic         m_tuser
);
	logic en;
	logic [INF_W-1:0] inf_q;
	logic last_inf, is_skin;
	logic [6:0] load_bone;
	logic [3:0] load_entry;
	logic [31:0] load_value;
	logic [2:0][31:0] pos;
	logic [63:0] weights;
	logic [31:0] bones;
	logic [15:0] w_sel;
	logic [7:0] bone_sel;
	logic bad_sel;
	mem_wr_t wr;
	bone_mat_t mat_s1;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic first_s1, first_s2, first_s3, first_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic bad_s1, bad_s2, bad_s3, bad_s4;
	logic [15:0] w_s1, w_s2, w_s3;
	logic [2:0][31:0] pos_s1;
	logic signed [63:0] prod_s2 [9];
	logic [2:0][31:0] m3_s2;
	logic signed [49:0] t_s3 [3];
	logic signed [66:0] wp [3];
	logic signed [51:0] c_s4 [3];
	logic signed [53:0] acc_q [3];
	logic signed [53:0] sum [3];
	logic bad_acc_q, bad_sum;
	logic out_valid_q;
	logic [95:0] out_data_q;
	logic out_status_q;

	function automatic logic [31:0] sat32(input logic signed [53:0] v);
		if (v > 54'sd2147483647) begin
			return 32'h7fff_ffff;
		end else if (v < -54'sd2147483648) begin
			return 32'h8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction

	assign load_bone  = s_tdata[6:0];
	assign load_entry = s_tdata[10:7];
	assign load_value = s_tdata[42:11];
	assign pos[0]     = s_tdata[74:43];
	assign pos[1]     = s_tdata[106:75];
	assign pos[2]     = s_tdata[138:107];
	assign weights    = s_tdata[202:139];
	assign bones      = s_tdata[234:203];

	assign en       = !out_valid_q || m_tready;
	assign last_inf = inf_q == INF_W'(INFLUENCE_COUNT - 1);
	assign is_skin  = s_tvalid && op_t'(s_tuser) == OP_SKIN;
	assign s_tready = en && (op_t'(s_tuser) == OP_LOAD || last_inf);
	assign w_sel    = 16'(weights >> {inf_q, 4'b0});
	assign bone_sel = 8'(bones >> {inf_q, 3'b0});
	assign bad_sel  = w_sel != 16'd0 && (bone_sel[7] || bone_sel[6:0] >= 7'(BONE_COUNT));

	always_comb begin
		wr.en = en && s_tvalid && op_t'(s_tuser) == OP_LOAD
			&& load_bone < 7'(BONE_COUNT) && load_entry < 4'(ENTRY_COUNT);
		wr.bone  = BONE_AW'(load_bone);
		wr.entry = load_entry;
		wr.value = load_value;
	end

	lbs_bone_mem u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (en),
		.rd_addr ((bone_sel[7] || bone_sel[6:0] >= 7'(BONE_COUNT)) ? '0
			: BONE_AW'(bone_sel[6:0])),
		.rd_data (mat_s1)
	);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			wp[r] = t_s3[r] * $signed({1'b0, w_s3});
			sum[r] = (first_s4 ? 54'sd0 : acc_q[r]) + 54'(c_s4[r]);
		end
		bad_sum = (!first_s4 && bad_acc_q) || bad_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inf_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			if (is_skin) begin
				inf_q <= last_inf ? '0 : inf_q + 1'b1;
			end
			vld_s1 <= is_skin;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			out_valid_q <= vld_s4 && last_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			first_s1 <= inf_q == '0;
			last_s1  <= last_inf;
			bad_s1   <= bad_sel;
			w_s1     <= w_sel;
			pos_s1   <= pos;

			first_s2 <= first_s1;
			last_s2  <= last_s1;
			bad_s2   <= bad_s1;
			w_s2     <= w_s1;
			for (int r = 0; r < 3; r++) begin
				m3_s2[r] <= mat_s1[r*4+3];
				for (int c = 0; c < 3; c++) begin
					prod_s2[r*3+c] <= $signed(mat_s1[r*4+c]) * $signed(pos_s1[c]);
				end
			end

			first_s3 <= first_s2;
			last_s3  <= last_s2;
			bad_s3   <= bad_s2;
			w_s3     <= w_s2;
			for (int r = 0; r < 3; r++) begin
				t_s3[r] <= 50'(prod_s2[r*3] >>> 16) + 50'(prod_s2[r*3+1] >>> 16)
					+ 50'(prod_s2[r*3+2] >>> 16) + 50'($signed(m3_s2[r]));
			end

			first_s4 <= first_s3;
			last_s4  <= last_s3;
			bad_s4   <= bad_s3;
			// zero weight skips the influence, whatever its bone holds
			for (int r = 0; r < 3; r++) begin
				c_s4[r] <= (w_s3 == 16'd0) ? 52'sd0 : 52'(wp[r] >>> 15);
			end

			if (vld_s4) begin
				for (int r = 0; r < 3; r++) begin
					acc_q[r] <= sum[r];
				end
				bad_acc_q <= bad_sum;
				if (last_s4) begin
					out_status_q <= bad_sum;
					for (int r = 0; r < 3; r++) begin
						out_data_q[r*32 +: 32] <= bad_sum ? 32'd0 : sat32(sum[r]);
					end
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;
endmodule

>>> hw/rtl/lbs_checker.sv
`timescale 1ns / 1ps
module lbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic        m_tuser
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed under stall");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 96'd0)
		else $error("bad bone result not zero");

	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while pipeline stalled");
endmodule

bind linear_blend_vertex_skinning lbs_checker u_lbs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
	import lbs_pkg::*;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        status;
	} skin_res_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [239:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic         m_tuser;

	logic signed [31:0] bone_mat [BONE_COUNT][ENTRY_COUNT];
	bit                 bone_loaded [BONE_COUNT];
	skin_res_t          skin_q[$];
	int                 send_idle_pct;
	int                 recv_stall_pct;
	int                 fail_count;
	int                 vertex_count;
	int                 load_count;
	int                 result_count;

	linear_blend_vertex_skinning u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic longint floor_shift(longint v, int n);
		return v >>> n;
	endfunction

	function automatic skin_res_t skin_vertex(logic [31:0] px, logic [31:0] py,
			logic [31:0] pz, logic [63:0] wts, logic [31:0] bones);
		skin_res_t res;
		longint p [3];
		longint acc [3];
		longint t, hi, lo, w, b;
		bit bad;
		p[0] = longint'(signed'(px));
		p[1] = longint'(signed'(py));
		p[2] = longint'(signed'(pz));
		acc = '{0, 0, 0};
		bad = 0;
		for (int i = 0; i < INFLUENCE_COUNT; i++) begin
			w = longint'(wts[16*i +: 16]);
			b = longint'(signed'(bones[8*i +: 8]));
			if (w == 0) continue;
			if (b < 0 || b >= BONE_COUNT) begin
				bad = 1;
				break;
			end
			for (int r = 0; r < 3; r++) begin
				t = longint'(bone_mat[b][r*4+3]);
				for (int c = 0; c < 3; c++)
					t += floor_shift(longint'(bone_mat[b][r*4+c]) * p[c], 16);
				hi = floor_shift(t, 15);
				lo = t - hi * 32768;
				acc[r] += hi * w + floor_shift(lo * w, 15);
			end
		end
		for (int r = 0; r < 3; r++) begin
			if (bad) acc[r] = 0;
			else if (acc[r] > 64'sd2147483647) acc[r] = 64'sd2147483647;
			else if (acc[r] < -64'sd2147483648) acc[r] = -64'sd2147483648;
		end
		res.x = acc[0][31:0];
		res.y = acc[1][31:0];
		res.z = acc[2][31:0];
		res.status = bad;
		return res;
	endfunction

	task automatic send_beat(op_t op, logic [6:0] lb, logic [3:0] le, logic [31:0] lv,
			logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [63:0] wts, logic [31:0] bones);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {5'd0, bones, wts, pz, py, px, lv, le, lb};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == OP_LOAD) begin
			load_count++;
			if (lb < BONE_COUNT && le < ENTRY_COUNT) begin
				bone_mat[lb][le] = lv;
				bone_loaded[lb] = 1;
			end
		end else begin
			vertex_count++;
			skin_q = {skin_q, skin_vertex(px, py, pz, wts, bones)};
		end
	endtask

	always @(posedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		skin_res_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			result_count++;
			if (skin_q.size() == 0) begin
				$error("result with nothing expected");
				fail_count++;
			end else begin
				exp_r = skin_q.pop_front();
				if (m_tdata[31:0] !== exp_r.x) begin
					$error("skinned_x exp %h got %h", exp_r.x, m_tdata[31:0]);
					fail_count++;
				end
				if (m_tdata[63:32] !== exp_r.y) begin
					$error("skinned_y exp %h got %h", exp_r.y, m_tdata[63:32]);
					fail_count++;
				end
				if (m_tdata[95:64] !== exp_r.z) begin
					$error("skinned_z exp %h got %h", exp_r.z, m_tdata[95:64]);
					fail_count++;
				end
				if (m_tuser !== exp_r.status) begin
					$error("status exp %0d got %0d", exp_r.status, m_tuser);
					fail_count++;
				end
			end
		end
	end

	task automatic load_bone(int b, bit extreme);
		logic [31:0] v;
		for (int e = 0; e < ENTRY_COUNT; e++) begin
			case ($urandom_range(5))
				0: v = extreme ? 32'h7fffffff : 32'h00010000;
				1: v = extreme ? 32'h80000000 : 32'hffff0000;
				2: v = $urandom;
				default: v = {{14{1'($urandom_range(1))}}, 18'($urandom)};
			endcase
			send_beat(OP_LOAD, 7'(b), 4'(e), v, $urandom, $urandom, $urandom,
				{$urandom, $urandom}, $urandom);
		end
	endtask

	function automatic logic [7:0] pick_bone(int bad_pct);
		int b;
		if ($urandom_range(99) < bad_pct)
			return $urandom_range(1) ? 8'($urandom_range(255, 128)) :
				8'($urandom_range(127, BONE_COUNT));
		do b = $urandom_range(BONE_COUNT - 1); while (!bone_loaded[b]);
		return 8'(b);
	endfunction

	task automatic skin_random(int bad_pct, bit big_pos);
		logic [63:0] wts;
		logic [31:0] bones;
		logic [31:0] p [3];
		for (int i = 0; i < 4; i++) begin
			case ($urandom_range(4))
				0: wts[16*i +: 16] = 16'd0;
				1: wts[16*i +: 16] = 16'hffff;
				2: wts[16*i +: 16] = 16'h8000;
				default: wts[16*i +: 16] = 16'($urandom);
			endcase
			bones[8*i +: 8] = (wts[16*i +: 16] == 0) ? 8'($urandom) : pick_bone(bad_pct);
		end
		for (int i = 0; i < 3; i++)
			p[i] = big_pos ? $urandom : {{12{1'($urandom_range(1))}}, 20'($urandom)};
		send_beat(OP_SKIN, 7'($urandom), 4'($urandom), $urandom, p[0], p[1], p[2],
			wts, bones);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (skin_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic test_directed();
		load_bone(0, 1);
		load_bone(BONE_COUNT - 1, 0);
		send_beat(OP_LOAD, 7'd100, 4'd0, 32'h12345678, '0, '0, '0, '0, '0);
		send_beat(OP_LOAD, 7'd127, 4'd15, 32'h12345678, '0, '0, '0, '0, '0);
		send_beat(OP_LOAD, 7'd0, 4'd12, 32'h12345678, '0, '0, '0, '0, '0);
		send_beat(OP_SKIN, '0, '0, '0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			64'hffff_ffff_ffff_ffff, 32'h00_63_00_00);
		send_beat(OP_SKIN, '0, '0, '0, 32'h80000000, 32'h80000000, 32'h80000000,
			64'hffff_ffff_ffff_ffff, 32'h63_63_00_00);
		send_beat(OP_SKIN, '0, '0, '0, 32'h00010000, '0, '0, 64'd0, 32'hffff_ffff);
		send_beat(OP_SKIN, '0, '0, '0, 32'h00010000, '0, '0, 64'h0001_0000_0000_0000,
			32'h80_00_00_00);
		send_beat(OP_SKIN, '0, '0, '0, 32'h00010000, '0, '0, 64'h8000, 32'h64);
		send_beat(OP_SKIN, '0, '0, '0, 32'h00010000, '0, '0, 64'h8000_0000_0000_8000,
			32'hff_00_00_00);
		send_beat(OP_SKIN, '0, '0, '0, $urandom, $urandom, $urandom, 64'h0000_0000_8000_0000,
			32'h00_00_63_9c);
		wait_drain();
	endtask

	task automatic test_random(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 3)
				load_bone($urandom_range(BONE_COUNT - 1), 1'($urandom_range(1)));
			else skin_random(10, $urandom_range(3) == 0);
		end
		wait_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fail_count = 0;
		vertex_count = 0;
		load_count = 0;
		result_count = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		for (int b = 1; b < BONE_COUNT - 1; b += 7) load_bone(b, 0);
		test_random(200, 0, 0);
		test_random(200, 57, 0);
		test_random(200, 0, 57);
		test_random(200, 13, 13);
		test_random(150, 0, 0);
		$display("covered %0d load beats and %0d vertices, %0d results checked",
			load_count, vertex_count, result_count);
		$display("including invalid bones, zero weights and saturating positions");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

>>> filelist.f
hw/rtl/lbs_pkg.sv
hw/rtl/lbs_bone_mem.sv
hw/rtl/linear_blend_vertex_skinning.sv
hw/rtl/lbs_checker.sv
sim/tb.sv
